FILE: src/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types and constants of the audio jitter buffer: word formats,
// operation codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package ajb_pkg;

   localparam int DEPTH     = 1024;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int LVL_W     = 11;
   localparam int SAMPLE_W  = 16;
   localparam int CNT_W     = 16;
   localparam int FRAME_W   = 2 * SAMPLE_W;
   localparam int CSR_IDX_W = 2;
   localparam int THR_W     = 11;

   localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

   localparam logic [THR_W-1:0] REBUF_THR_RST = THR_W'(256);
   localparam logic [THR_W-1:0] AUTO_THR_RST  = THR_W'(512);

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_PULL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_REBUF_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_THR  = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_word;
      logic               frame_real;
      logic               push_accepted;
      logic [LVL_W-1:0]   fill_level;
      logic [CNT_W-1:0]   underrun_total;
      logic [CNT_W-1:0]   overrun_total;
      logic               rebuffering_now;
      logic               playing;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic store;
      logic count_ovr;
      logic fetch;
      logic count_und;
      logic set_rebuf;
      logic clr_rebuf;
      logic set_run;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic auto_now;
      logic auto_push;
      logic rebuf_met;
      logic running;
      logic rebuf;
   } stat_type;

endpackage

FILE: src/audio_jitter_buffer_rebuffer_core.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer_rebuffer_core
// Stereo audio jitter buffer with autostart and rebuffer after underrun.
// ----------------------------------------------------------------------------
// Each command (push, pull, clear) is taken when start is high and busy is
// low. Its response word appears on rsp_data with rsp_strobe high for one
// cycle, after the command has passed through the execute state; the
// receiver cannot stall it. busy is high only in the cycle after a command,
// so a new command can be issued in the same cycle the previous response is
// strobed, but not while the previous command is still executing. The
// 1024-entry ring RAM has a registered read port.
// Threshold writes on the csr_ port are always accepted and must only be
// issued while no command is outstanding.
// ----------------------------------------------------------------------------
module audio_jitter_buffer_rebuffer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ajb_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output ajb_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ajb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ajb_pkg::THR_W-1:0]     csr_wdata
);
   import ajb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   ajb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_data.operation),
      .stat       (stat),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   ajb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command not executed after accept");

   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("no response after execute");

   a_real_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.frame_real && rsp_data.push_accepted))
      else $error("pull and push both reported");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.fill_level <= DEPTH_LVL))
      else $error("fill level out of range");

   a_silence: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.frame_real) |-> (rsp_data.frame_word == '0))
      else $error("silence word not zero");

endmodule

FILE: src/ajb_ctrl.sv
// ----------------------------------------------------------------------------
// ajb_ctrl
// Sequencer: takes a request, decides the buffer actions from datapath
// status, and strobes the response after the execute state.
// ----------------------------------------------------------------------------
module ajb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_op,
   input  ajb_pkg::stat_type stat,
   output logic             busy,
   output logic             rsp_strobe,
   output ajb_pkg::cmd_type cmd
);
   import ajb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       accept;
   logic       run_eff;
   logic       go;

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign accept     = start && !busy;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               state_in = ST_EXEC;
               op_in    = req_op;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: state_in = ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      run_eff     = stat.running || stat.auto_now;
      go          = !stat.rebuf || stat.rebuf_met;
      if (state_ff == ST_EXEC) begin
         cmd.exec = 1'b1;
         case (op_ff)
            OP_PUSH: begin
               if (stat.full) begin
                  cmd.count_ovr = 1'b1;
                  cmd.set_run   = !stat.running && stat.auto_now;
               end else begin
                  cmd.store   = 1'b1;
                  cmd.set_run = !stat.running && stat.auto_push;
               end
            end
            OP_PULL: begin
               cmd.set_run = !stat.running && stat.auto_now;
               if (run_eff) begin
                  cmd.clr_rebuf = stat.rebuf && stat.rebuf_met;
                  if (go) begin
                     if (stat.empty) begin
                        cmd.count_und = 1'b1;
                        cmd.set_rebuf = 1'b1;
                     end else begin
                        cmd.fetch = 1'b1;
                     end
                  end
               end
            end
            OP_CLEAR: cmd.clear_all = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_PUSH;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

FILE: src/ajb_dpath.sv
// ----------------------------------------------------------------------------
// ajb_dpath
// Ring store, pointers, fill level, counters, playback flags and
// configuration thresholds.
// ----------------------------------------------------------------------------
module ajb_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ajb_pkg::req_type                req_data,
   input  ajb_pkg::cmd_type                cmd,
   input  logic                            csr_we,
   input  logic [ajb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ajb_pkg::THR_W-1:0]       csr_wdata,
   output ajb_pkg::stat_type               stat,
   output ajb_pkg::rsp_type                rsp_data
);
   import ajb_pkg::*;

   logic [FRAME_W-1:0] store_ff [DEPTH];
   logic [FRAME_W-1:0] rdata_ff;
   logic [FRAME_W-1:0] pair_ff;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [CNT_W-1:0] und_ff, und_in;
   logic [CNT_W-1:0] ovr_ff, ovr_in;
   logic             rebuf_ff, rebuf_in;
   logic             run_ff, run_in;
   logic             real_ff, real_in;
   logic             acc_ff, acc_in;
   logic [THR_W-1:0] rebuf_thr_ff, rebuf_thr_in;
   logic [THR_W-1:0] auto_thr_ff, auto_thr_in;
   logic [LVL_W-1:0] lvl_plus;

   assign lvl_plus = lvl_ff + LVL_W'(1);

   assign stat.full      = (lvl_ff >= DEPTH_LVL);
   assign stat.empty     = (lvl_ff == '0);
   assign stat.auto_now  = (lvl_ff >= auto_thr_ff);
   assign stat.auto_push = (lvl_plus >= auto_thr_ff);
   assign stat.rebuf_met = (lvl_ff >= rebuf_thr_ff);
   assign stat.running   = run_ff;
   assign stat.rebuf     = rebuf_ff;

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      lvl_in       = lvl_ff;
      und_in       = und_ff;
      ovr_in       = ovr_ff;
      rebuf_in     = rebuf_ff;
      run_in       = run_ff;
      real_in      = real_ff;
      acc_in       = acc_ff;
      rebuf_thr_in = rebuf_thr_ff;
      auto_thr_in  = auto_thr_ff;

      if (cmd.exec) begin
         real_in = cmd.fetch;
         acc_in  = cmd.store;
      end
      if (cmd.store) begin
         wp_in  = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
         lvl_in = lvl_plus;
      end
      if (cmd.fetch) begin
         rp_in  = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
         lvl_in = lvl_ff - LVL_W'(1);
      end
      if (cmd.count_ovr && ovr_ff != '1) ovr_in = ovr_ff + CNT_W'(1);
      if (cmd.count_und && und_ff != '1) und_in = und_ff + CNT_W'(1);
      if (cmd.clr_rebuf) rebuf_in = 1'b0;
      if (cmd.set_rebuf) rebuf_in = 1'b1;
      if (cmd.set_run)   run_in   = 1'b1;
      if (cmd.clear_all) begin
         wp_in    = '0;
         rp_in    = '0;
         lvl_in   = '0;
         und_in   = '0;
         ovr_in   = '0;
         rebuf_in = 1'b0;
         run_in   = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            REG_REBUF_THR: rebuf_thr_in = csr_wdata;
            REG_AUTO_THR:  auto_thr_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         lvl_ff       <= '0;
         und_ff       <= '0;
         ovr_ff       <= '0;
         rebuf_ff     <= 1'b0;
         run_ff       <= 1'b0;
         real_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         rebuf_thr_ff <= REBUF_THR_RST;
         auto_thr_ff  <= AUTO_THR_RST;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         lvl_ff       <= lvl_in;
         und_ff       <= und_in;
         ovr_ff       <= ovr_in;
         rebuf_ff     <= rebuf_in;
         run_ff       <= run_in;
         real_ff      <= real_in;
         acc_ff       <= acc_in;
         rebuf_thr_ff <= rebuf_thr_in;
         auto_thr_ff  <= auto_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pair_ff <= {req_data.left_sample, req_data.right_sample};
      end
   end

   // ring store: one write or one read per item
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_ff[wp_ff] <= pair_ff;
      end
      if (cmd.fetch) begin
         rdata_ff <= store_ff[rp_ff];
      end
   end

   assign rsp_data.frame_word      = real_ff ? rdata_ff : '0;
   assign rsp_data.frame_real      = real_ff;
   assign rsp_data.push_accepted   = acc_ff;
   assign rsp_data.fill_level      = lvl_ff;
   assign rsp_data.underrun_total  = und_ff;
   assign rsp_data.overrun_total   = ovr_ff;
   assign rsp_data.rebuffering_now = rebuf_ff;
   assign rsp_data.playing         = run_ff;

endmodule
